// File: rtl/core/mrwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwt_pkg: shared types and constants for the Miller-Rabin witness test
// Sequencer states, the multiplier handshake struct and the default operand width.
// ----------------------------------------------------------------------------
package mrwt_pkg;

  localparam int NUMBER_BITS_DEF = 63;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD_BASE,
    ST_POW_STEP,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_CHECK,
    ST_SQ_LOOP,
    ST_DONE
  } mrwt_state_t;

  typedef struct packed {
    logic start;
    logic done;
  } mrwt_hs_t;

endpackage

// File: rtl/core/mrwt_modmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwt_modmul: bit-serial modular multiplier
// Computes (x * y) mod n, one bit of y per cycle, most significant first.
// ----------------------------------------------------------------------------
module mrwt_modmul #(
  parameter int W = mrwt_pkg::NUMBER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mrwt_pkg::mrwt_hs_t ctl_i,
  input  logic [W-1:0]      x_i,
  input  logic [W-1:0]      y_i,
  input  logic [W-1:0]      n_i,
  output logic              done_o,
  output logic [W-1:0]      p_o
);
  import mrwt_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    dbl, dsub, add, asub;
  logic [W-1:0]  a1;

  always_comb begin
    dbl  = {acc_r, 1'b0};
    dsub = dbl - {1'b0, n_i};
    a1   = dsub[W] ? dbl[W-1:0] : dsub[W-1:0];
    add  = {1'b0, a1} + {1'b0, x_i};
    asub = add - {1'b0, n_i};
    acc_nxt  = acc_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl_i.start) begin
      acc_nxt  = '0;
      y_nxt    = y_i;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (y_r[W-1]) begin
        acc_nxt = asub[W] ? add[W-1:0] : asub[W-1:0];
      end else begin
        acc_nxt = a1;
      end
      y_nxt   = {y_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    y_r   <= y_nxt;
  end

  assign done_o = done_r;
  assign p_o    = acc_r;
endmodule

// File: rtl/core/miller_rabin_witness_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_witness_test: one-round strong probable-prime test
// Usage:
//   Present candidate and witness base on in_* with in_valid; the item is
//   taken when in_valid and in_ready are high. One result (out_passes)
//   follows on out_* under out_valid/out_ready.
//   Small and even candidates raise out_valid the cycle after acceptance.
//   Otherwise the base is reduced mod n by one bit-serial multiply by 1,
//   then square-and-multiply runs over the bits of d and up to r-1
//   squarings follow. Each modular multiply runs on one shared bit-serial
//   unit, and a 63-bit candidate needs up to 125 multiplies.
//   One item is in flight at a time; in_ready is low while it is worked on
//   and while its result waits. A stalled receiver holds out_valid and the
//   result. Synchronous reset (rst_n low) empties the block and drops any
//   item in progress.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test #(
  parameter int NUMBER_BITS = mrwt_pkg::NUMBER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [NUMBER_BITS-1:0] in_candidate,
  input  logic [NUMBER_BITS-1:0] in_witness_base,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_passes
);
  import mrwt_pkg::*;

  localparam int W  = NUMBER_BITS;
  localparam int RW = $clog2(W + 1);

  mrwt_state_t   st_r, st_nxt;
  logic [W-1:0]  n_r, n_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  e_r, e_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [RW-1:0] r_r, r_nxt;
  logic          pass_r, pass_nxt;

  mrwt_hs_t     mm_ctl;
  logic [W-1:0] mm_x, mm_y, mm_p;
  logic         mm_done;
  logic [W-1:0] nm1;
  logic [W-1:0] dd;
  logic [RW-1:0] rr;
  logic         tiny;
  logic         small_pass;

  assign nm1 = n_r - 1'b1;

  // trailing zero count of n-1 by a priority scan over all W bits
  always_comb begin
    dd = in_candidate - 1'b1;
    rr = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (dd[i]) rr = RW'(i);
    end
  end

  always_comb begin
    tiny       = (in_candidate < W'(15)) || !in_candidate[0];
    small_pass = 1'b0;
    if (in_candidate < W'(2)) small_pass = 1'b0;
    else if (!in_candidate[0]) small_pass = (in_candidate == W'(2));
    else small_pass = (in_candidate != W'(9));
  end

  mrwt_modmul #(.W(W)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (mm_ctl),
    .x_i    (mm_x),
    .y_i    (mm_y),
    .n_i    (n_r),
    .done_o (mm_done),
    .p_o    (mm_p)
  );

  // next state and datapath
  always_comb begin
    st_nxt   = st_r;
    n_nxt    = n_r;
    b_nxt    = b_r;
    e_nxt    = e_r;
    x_nxt    = x_r;
    r_nxt    = r_r;
    pass_nxt = pass_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt = in_candidate;
          b_nxt = in_witness_base;
          e_nxt = dd >> rr;
          r_nxt = rr;
          x_nxt = W'(1);
          if (tiny) begin
            pass_nxt = small_pass;
            st_nxt   = ST_DONE;
          end else begin
            st_nxt = ST_MOD_BASE;
          end
        end
      end
      ST_MOD_BASE: begin
        // base * 1 mod n: the multiplier only ever reduces a subtractive
        // chain, so feed reduced-by-doubling form through it
        if (mm_done) begin
          b_nxt  = mm_p;
          st_nxt = ST_POW_STEP;
        end
      end
      ST_POW_STEP: begin
        if (e_r == '0) st_nxt = ST_CHECK;
        else if (e_r[0]) st_nxt = ST_POW_MUL;
        else st_nxt = ST_POW_SQR;
      end
      ST_POW_MUL: begin
        if (mm_done) begin
          x_nxt  = mm_p;
          st_nxt = ST_POW_SQR;
        end
      end
      ST_POW_SQR: begin
        if (mm_done) begin
          b_nxt  = mm_p;
          e_nxt  = e_r >> 1;
          st_nxt = ST_POW_STEP;
        end
      end
      ST_CHECK: begin
        if (x_r == W'(1) || x_r == nm1) begin
          pass_nxt = 1'b1;
          st_nxt   = ST_DONE;
        end else if (r_r <= RW'(1)) begin
          pass_nxt = 1'b0;
          st_nxt   = ST_DONE;
        end else begin
          st_nxt = ST_SQ_LOOP;
        end
      end
      ST_SQ_LOOP: begin
        if (mm_done) begin
          x_nxt = mm_p;
          r_nxt = r_r - 1'b1;
          if (mm_p == nm1) begin
            pass_nxt = 1'b1;
            st_nxt   = ST_DONE;
          end else if (r_r <= RW'(2)) begin
            pass_nxt = 1'b0;
            st_nxt   = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // launch: start fires entering a multiply state and per ST_SQ_LOOP pass
  logic launch_r, launch_nxt;
  always_comb begin
    launch_nxt = 1'b0;
    case (st_nxt)
      ST_MOD_BASE, ST_POW_MUL, ST_POW_SQR, ST_SQ_LOOP:
        launch_nxt = (st_nxt != st_r) || mm_done;
      default: launch_nxt = 1'b0;
    endcase
  end

  always_comb begin
    mm_ctl.start = launch_r;
    mm_ctl.done  = mm_done;
    case (st_r)
      ST_MOD_BASE: begin
        mm_x = W'(1);
        mm_y = b_r;
      end
      ST_POW_MUL: begin
        mm_x = x_r;
        mm_y = b_r;
      end
      ST_POW_SQR: begin
        mm_x = b_r;
        mm_y = b_r;
      end
      default: begin
        mm_x = x_r;
        mm_y = x_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      launch_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      launch_r <= launch_nxt;
    end
    n_r    <= n_nxt;
    b_r    <= b_nxt;
    e_r    <= e_nxt;
    x_r    <= x_nxt;
    r_r    <= r_nxt;
    pass_r <= pass_nxt;
  end

  assign in_ready   = (st_r == ST_IDLE);
  assign out_valid  = (st_r == ST_DONE);
  assign out_passes = pass_r;
endmodule
